// File: rtl/csk_pkg.sv
// Shared types, constants and small tables for the cosine-similarity top-k ranker.
`default_nettype none

package csk_pkg;

    localparam int NUM_GENRES = 5;
    localparam int W_BITS     = 2;   // profile weight
    localparam int DOT_W      = 4;   // dot <= 15
    localparam int DSQ_W      = 8;   // dot squared <= 225
    localparam int NB_W       = 3;   // popcount of a mask <= 5
    localparam int NA_W       = 6;   // sum of squared weights <= 45
    localparam int PROD_W     = 8;   // normA * normB <= 225
    localparam int CMP_W      = 11;  // dot^2 * popcount <= 1125
    localparam int Q_BITS     = 16;  // Q1.15 score
    localparam int QACC_W     = 24;  // prod * s
    localparam int ACC_W      = 40;  // prod * s^2 and dot^2 << 30
    localparam int RHS_SHIFT  = 30;

    localparam int ID_W       = 16;
    localparam int MASK_W     = 5;
    localparam int RANK_W     = 2;
    localparam int S_TDATA_W  = 24;  // id, mask, zero fill
    localparam int M_TDATA_W  = 40;  // rank, id, mask, score, zero fill
    localparam int CFG_IDX_W  = 3;

    localparam int TOP_K_DEF   = 3;
    localparam int ID_BITS_DEF = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_W_ACTION    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_W_COMEDY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_W_DRAMA     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_W_SCIFI     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_W_ANIMATION = 3'd4;

    localparam logic [DSQ_W-1:0] SQ4_TABLE [16] = '{
        8'd0,   8'd1,   8'd4,   8'd9,   8'd16,  8'd25,  8'd36,  8'd49,
        8'd64,  8'd81,  8'd100, 8'd121, 8'd144, 8'd169, 8'd196, 8'd225
    };

    localparam logic [3:0] SQ2_TABLE [4] = '{4'd0, 4'd1, 4'd4, 4'd9};

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_START,
        S_ROOT,
        S_LOAD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic insert;
        logic idx_clear;
        logic idx_next;
        logic root_start;
        logic root_step;
        logic load_out;
        logic load_empty;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic in_last;
        logic count_zero;
        logic entry_last;
        logic root_last;
    } t_status;

    function automatic logic [NB_W-1:0] popcount5(input logic [MASK_W-1:0] m);
        logic [NB_W-1:0] c;
        c = '0;
        for (int g = 0; g < MASK_W; g++) begin
            c = c + NB_W'(m[g]);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/cosine_similarity_top_k.sv
// Top level of the streaming cosine-similarity top-k ranker.
`default_nettype none

// Each input word is one catalog item, scored against a five-weight genre
// profile by cosine similarity; the TOP_K best items with a nonzero score
// are kept, ties going to the earlier item. An item is accepted, then
// inserted while the input is not ready, comparing against all kept
// entries in parallel. On the item with tlast set, the list is read out
// best first: each entry passes through the score unit (a start step, the
// bit-serial Q1.15 root, a load step) and then waits in the output
// register until taken. An empty list gives one word with found (tuser)
// low. The input is not ready during readout, and the list is cleared after
// the last result word is taken. Profile weights are written through the
// config channel, always ready; index 0..4 = action, comedy, drama, scifi,
// animation, other indexes are ignored. Write config only while idle.
module cosine_similarity_top_k #(
    parameter int TOP_K   = csk_pkg::TOP_K_DEF,   // kept entries, 1..4
    parameter int ID_BITS = csk_pkg::ID_BITS_DEF  // stored id bits, 4..32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // config write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [csk_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [csk_pkg::W_BITS-1:0]     i_cfg_data,
    // item stream
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [csk_pkg::S_TDATA_W-1:0]  i_s_tdata,  // item_id, genre_mask, zero fill
    input  wire logic                           i_s_tuser,  // skip_item
    input  wire logic                           i_s_tlast,  // end_of_catalog
    // result stream
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [csk_pkg::M_TDATA_W-1:0]       o_m_tdata,  // rank, best_id, best_mask,
                                                            // similarity_q15, zero fill
    output logic                                o_m_tuser,  // found
    output logic                                o_m_tlast   // last_result
);
    import csk_pkg::*;

    t_cmd    cmd;
    t_status status;

    logic [RANK_W-1:0] rank;
    logic [ID_W-1:0]   best_id;
    logic [MASK_W-1:0] best_mask;
    logic [Q_BITS-1:0] sim;

    // config registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    csk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid)
    );

    csk_dp #(
        .TOP_K   (TOP_K),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_item_id        (i_s_tdata[ID_W-1:0]),
        .i_genre_mask     (i_s_tdata[ID_W+MASK_W-1:ID_W]),
        .i_skip_item      (i_s_tuser),
        .i_end_of_catalog (i_s_tlast),
        .o_rank           (rank),
        .o_best_id        (best_id),
        .o_best_mask      (best_mask),
        .o_similarity_q15 (sim),
        .o_found          (o_m_tuser),
        .o_last_result    (o_m_tlast)
    );

    // result word, lowest field first
    assign o_m_tdata = {1'b0, sim, best_mask, best_id, rank};

endmodule

`default_nettype wire

// File: rtl/csk_ctrl.sv
// Sequencer for item insertion and ranked readout.
`default_nettype none

module csk_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    input  wire logic             i_m_tready,
    input  wire csk_pkg::t_status i_status,
    output csk_pkg::t_cmd         o_cmd,
    output logic                  o_s_tready,
    output logic                  o_m_tvalid
);
    import csk_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_INSERT;
                end
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                if (i_status.in_last) begin
                    o_cmd.idx_clear = 1'b1;
                    n_state         = S_START;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_START: begin
                if (i_status.count_zero) begin
                    o_cmd.load_empty = 1'b1;
                    n_state          = S_OUT;
                end else begin
                    o_cmd.root_start = 1'b1;
                    n_state          = S_ROOT;
                end
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_out = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    if (i_status.entry_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        o_cmd.idx_next = 1'b1;
                        n_state        = S_START;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/csk_dp.sv
// Datapath: profile registers, kept list with ordered insertion, bit-serial score root.
`default_nettype none

module csk_dp #(
    parameter int TOP_K   = csk_pkg::TOP_K_DEF,
    parameter int ID_BITS = csk_pkg::ID_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire csk_pkg::t_cmd                 i_cmd,
    output csk_pkg::t_status                   o_status,
    input  wire logic                          i_cfg_we,
    input  wire logic [csk_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [csk_pkg::W_BITS-1:0]    i_cfg_data,
    input  wire logic [csk_pkg::ID_W-1:0]      i_item_id,
    input  wire logic [csk_pkg::MASK_W-1:0]    i_genre_mask,
    input  wire logic                          i_skip_item,
    input  wire logic                          i_end_of_catalog,
    output logic [csk_pkg::RANK_W-1:0]         o_rank,
    output logic [csk_pkg::ID_W-1:0]           o_best_id,
    output logic [csk_pkg::MASK_W-1:0]         o_best_mask,
    output logic [csk_pkg::Q_BITS-1:0]         o_similarity_q15,
    output logic                               o_found,
    output logic                               o_last_result
);
    import csk_pkg::*;

    localparam int CNT_W  = $clog2(TOP_K + 1);
    localparam int IDX_W  = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam int BIT_W  = $clog2(Q_BITS);

    // profile
    logic [W_BITS-1:0] r_w [NUM_GENRES];

    // held input word
    logic [ID_BITS-1:0] r_in_id;
    logic [MASK_W-1:0]  r_in_mask;
    logic               r_in_skip;
    logic               r_in_last;

    // kept list, best first
    logic [ID_BITS-1:0] r_id   [TOP_K];
    logic [MASK_W-1:0]  r_mask [TOP_K];
    logic [DOT_W-1:0]   r_dot  [TOP_K];
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_idx;

    // root unit
    logic [PROD_W-1:0]  r_prod;
    logic [ACC_W-1:0]   r_rhs;
    logic [ACC_W-1:0]   r_p;
    logic [QACC_W-1:0]  r_q;
    logic [Q_BITS-1:0]  r_s;
    logic [BIT_W-1:0]   r_bit;

    // output word
    logic [RANK_W-1:0]  r_out_rank;
    logic [ID_W-1:0]    r_out_id;
    logic [MASK_W-1:0]  r_out_mask;
    logic [Q_BITS-1:0]  r_out_sim;
    logic               r_out_found;
    logic               r_out_last;

    // ---------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_GENRES; g++) begin
                r_w[g] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_W_ACTION:    r_w[0] <= i_cfg_data;
                CFG_W_COMEDY:    r_w[1] <= i_cfg_data;
                CFG_W_DRAMA:     r_w[2] <= i_cfg_data;
                CFG_W_SCIFI:     r_w[3] <= i_cfg_data;
                CFG_W_ANIMATION: r_w[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- scoring of the held item
    logic [DOT_W-1:0] new_dot;
    logic [NB_W-1:0]  new_nb;
    logic [DSQ_W-1:0] new_dsq;
    logic [NA_W-1:0]  norm_a;
    logic [TOP_K-1:0] better;
    logic [CNT_W-1:0] pos;
    logic             do_ins;

    always_comb begin
        new_dot = '0;
        norm_a  = '0;
        for (int g = 0; g < NUM_GENRES; g++) begin
            if (r_in_mask[g]) begin
                new_dot = new_dot + DOT_W'(r_w[g]);
            end
            norm_a = norm_a + NA_W'(SQ2_TABLE[r_w[g]]);
        end
        new_nb  = popcount5(r_in_mask);
        new_dsq = SQ4_TABLE[new_dot];
    end

    always_comb begin
        for (int i = 0; i < TOP_K; i++) begin
            better[i] = (CNT_W'(i) < r_count) &&
                        ((CMP_W'(new_dsq) * CMP_W'(popcount5(r_mask[i]))) >
                         (CMP_W'(SQ4_TABLE[r_dot[i]]) * CMP_W'(new_nb)));
        end
        pos = r_count;
        for (int i = TOP_K - 1; i >= 0; i--) begin
            if (better[i]) begin
                pos = CNT_W'(i);
            end
        end
        do_ins = !r_in_skip && (new_dot != '0) && (pos < CNT_W'(TOP_K));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_id   <= ID_BITS'(i_item_id);
            r_in_mask <= i_genre_mask;
            r_in_skip <= i_skip_item;
            r_in_last <= i_end_of_catalog;
        end
        if (i_cmd.insert && do_ins) begin
            for (int i = 0; i < TOP_K; i++) begin
                if (CNT_W'(i) == pos) begin
                    r_id[i]   <= r_in_id;
                    r_mask[i] <= r_in_mask;
                    r_dot[i]  <= new_dot;
                end else if (CNT_W'(i) > pos && CNT_W'(i) <= r_count) begin
                    // shift down one place; the worst entry falls off the end
                    r_id[i]   <= r_id[(i == 0) ? 0 : i - 1];
                    r_mask[i] <= r_mask[(i == 0) ? 0 : i - 1];
                    r_dot[i]  <= r_dot[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.insert && do_ins && r_count < CNT_W'(TOP_K)) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.idx_clear) begin
                r_idx <= '0;
            end else if (i_cmd.idx_next) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // ---------------- bit-serial root: largest s with s^2*prod <= dot^2 << 30
    // s^2*prod is tracked as r_p and s*prod as r_q, so trying bit b costs
    // only adds: (s|2^b)^2*prod = P + (Q << (b+1)) + (prod << 2b)
    logic [ACC_W-1:0] cand;

    always_comb begin
        cand = r_p + ((ACC_W'(r_q) << r_bit) << 1) + (ACC_W'(r_prod) << {r_bit, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_start) begin
            r_prod <= PROD_W'(norm_a) * PROD_W'(popcount5(r_mask[r_idx]));
            r_rhs  <= ACC_W'(SQ4_TABLE[r_dot[r_idx]]) << RHS_SHIFT;
            r_p    <= '0;
            r_q    <= '0;
            r_s    <= '0;
            r_bit  <= BIT_W'(Q_BITS - 1);
        end else if (i_cmd.root_step) begin
            if (cand <= r_rhs) begin
                r_p        <= cand;
                r_q        <= r_q + (QACC_W'(r_prod) << r_bit);
                r_s[r_bit] <= 1'b1;
            end
            r_bit <= r_bit - 1'b1;
        end
    end

    // ---------------- output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_rank  <= RANK_W'(r_idx);
            r_out_id    <= ID_W'(r_id[r_idx]);
            r_out_mask  <= r_mask[r_idx];
            r_out_sim   <= r_s;
            r_out_found <= 1'b1;
            r_out_last  <= o_status.entry_last;
        end else if (i_cmd.load_empty) begin
            r_out_rank  <= '0;
            r_out_id    <= '0;
            r_out_mask  <= '0;
            r_out_sim   <= '0;
            r_out_found <= 1'b0;
            r_out_last  <= 1'b1;
        end
    end

    always_comb begin
        o_status.in_last    = r_in_last;
        o_status.count_zero = (r_count == '0);
        o_status.entry_last = ((CNT_W + 1)'(r_idx) + 1'b1) >= (CNT_W + 1)'(r_count);
        o_status.root_last  = (r_bit == '0);
    end

    assign o_rank           = r_out_rank;
    assign o_best_id        = r_out_id;
    assign o_best_mask      = r_out_mask;
    assign o_similarity_q15 = r_out_sim;
    assign o_found          = r_out_found;
    assign o_last_result    = r_out_last;

endmodule

`default_nettype wire

// File: rtl/csk_checker.sv
// Port-level checks on the ranker's stream behavior, bound to the top level.
`default_nettype none

module csk_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          o_s_tready,
    input wire logic                          i_s_tlast,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [csk_pkg::M_TDATA_W-1:0] o_m_tdata,
    input wire logic                          o_m_tuser,
    input wire logic                          o_m_tlast
);
    import csk_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    // no new item is taken while a result is on offer
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input ready during readout");

    // an ordinary item produces no result, and leaves the input not ready, right after it
    a_plain_item_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tlast |=> !o_m_tvalid && !o_s_tready)
        else $error("result or ready right after a non-final item");

    // the empty-list word is a single final word with rank zero
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tlast && (o_m_tdata[RANK_W-1:0] == '0))
        else $error("malformed empty-list result");

    // taking the final result ends the readout
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tlast |=> !o_m_tvalid && o_s_tready)
        else $error("readout did not end after final result");

endmodule

bind cosine_similarity_top_k csk_checker u_csk_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the cosine-similarity top-k ranker: random and directed catalogs.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csk_pkg::*;

    // one catalog word as the bench sees it
    typedef struct {
        logic [ID_W-1:0]   id;
        logic [MASK_W-1:0] mask;
        logic              skip;
        logic              eoc;      // end of catalog
    } t_catalog_item;

    // one ranked result word
    typedef struct {
        logic [RANK_W-1:0] rank;
        logic [ID_W-1:0]   id;
        logic [MASK_W-1:0] mask;
        logic [Q_BITS-1:0] score;
        logic              found;
        logic              last_res;
    } t_ranking_word;

    localparam int KEEP = TOP_K_DEF;

    // ---------------------------------------------------------------
    // clock, reset and DUT-facing signals (bench-driven ones known from time zero)
    // ---------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [W_BITS-1:0]    cfg_data = '0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 s_tlast = 1'b0;

    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    always #4 clk = ~clk;

    cosine_similarity_top_k dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),    // item_id, genre_mask, zero fill
        .i_s_tuser   (s_tuser),    // skip_item
        .i_s_tlast   (s_tlast),    // end_of_catalog
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),    // rank, best_id, best_mask, similarity_q15, zero fill
        .o_m_tuser   (m_tuser),    // found
        .o_m_tlast   (m_tlast)     // last_result
    );

    // ---------------------------------------------------------------
    // bench state
    // ---------------------------------------------------------------
    t_catalog_item items_to_send[$];
    t_catalog_item item_on_bus;
    t_ranking_word pending_rankings[$];

    // shadow of the profile and of the kept list
    logic [W_BITS-1:0] profile_w [NUM_GENRES];
    logic [ID_W-1:0]   top_ids   [KEEP];
    logic [MASK_W-1:0] top_masks [KEEP];
    logic [DOT_W-1:0]  top_dots  [KEEP];
    int                top_count = 0;

    int send_idle_pct = 0;      // chance in 100 that the sender idles a cycle
    int recv_stall_pct = 0;     // chance in 100 that the sink stalls a cycle

    int error_count = 0;
    int items_accepted = 0;
    int words_checked = 0;
    int catalogs_closed = 0;
    int profile_writes = 0;

    // ---------------------------------------------------------------
    // scoring: largest s (16 bits, saturating) with
    // s^2 * normA * normB <= dot^2 * 2^30, found bit by bit from the top
    // ---------------------------------------------------------------
    function automatic logic [Q_BITS-1:0] q15_cosine(input int dot, input int norm_p,
                                                     input int norm_m);
        longint unsigned bound;
        longint unsigned norms;
        longint unsigned trial;
        logic [Q_BITS-1:0] s;
        bound = longint'(dot * dot) << RHS_SHIFT;
        norms = longint'(norm_p * norm_m);
        s = '0;
        for (int b = Q_BITS - 1; b >= 0; b--) begin
            trial = longint'(s) | (64'd1 << b);
            if (trial * trial * norms <= bound) begin
                s[b] = 1'b1;
            end
        end
        return s;
    endfunction

    // ---------------------------------------------------------------
    // ranking predictor: updates the kept list for one accepted word and
    // queues the words the end of a catalog produces
    // ---------------------------------------------------------------
    task automatic rank_catalog_item(input t_catalog_item it);
        int dot;
        int ones;
        int pos;
        int tail;
        int norm_p;
        t_ranking_word w;
        if (!it.skip) begin
            dot = 0;
            for (int g = 0; g < NUM_GENRES; g++) begin
                if (it.mask[g]) dot += int'(profile_w[g]);
            end
            if (dot > 0) begin
                ones = $countones(it.mask);
                pos = top_count;
                // strictly better only, so ties keep the earlier item ahead
                for (int i = 0; i < top_count; i++) begin
                    if (pos == top_count &&
                        dot * dot * $countones(top_masks[i]) >
                        int'(top_dots[i]) * int'(top_dots[i]) * ones) begin
                        pos = i;
                    end
                end
                if (pos < KEEP) begin
                    tail = (top_count < KEEP) ? top_count : KEEP - 1;
                    for (int i = tail; i > pos; i--) begin
                        top_ids[i]   = top_ids[i-1];
                        top_masks[i] = top_masks[i-1];
                        top_dots[i]  = top_dots[i-1];
                    end
                    top_ids[pos]   = it.id;
                    top_masks[pos] = it.mask;
                    top_dots[pos]  = DOT_W'(dot);
                    if (top_count < KEEP) top_count++;
                end
            end
        end

        if (it.eoc) begin
            catalogs_closed++;
            if (top_count == 0) begin
                // nothing scored above zero: one word with found low
                w = '{rank: '0, id: '0, mask: '0, score: '0, found: 1'b0, last_res: 1'b1};
                pending_rankings = {pending_rankings, w};
            end else begin
                // output score uses the profile as it stands now
                norm_p = 0;
                for (int g = 0; g < NUM_GENRES; g++) begin
                    norm_p += int'(profile_w[g]) * int'(profile_w[g]);
                end
                for (int i = 0; i < top_count; i++) begin
                    w.rank     = RANK_W'(i);
                    w.id       = top_ids[i];
                    w.mask     = top_masks[i];
                    w.score    = q15_cosine(int'(top_dots[i]), norm_p,
                                            $countones(top_masks[i]));
                    w.found    = 1'b1;
                    w.last_res = (i == top_count - 1);
                    pending_rankings = {pending_rankings, w};
                end
                top_count = 0;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // item driver: pops the next word when the bus is free, predicts on accept
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                items_accepted++;
                rank_catalog_item(item_on_bus);
            end
            if (!s_tvalid || s_tready) begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item_on_bus = items_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, item_on_bus.mask, item_on_bus.id};
                    s_tuser  <= item_on_bus.skip;
                    s_tlast  <= item_on_bus.eoc;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [Q_BITS-1:0] want,
                               input logic [Q_BITS-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // ---------------------------------------------------------------
    // result monitor: random backpressure, field-by-field compare
    // ---------------------------------------------------------------
    always @(posedge clk) begin : result_monitor
        t_ranking_word want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_rankings.size() == 0) begin
                    $display("%0t: unexpected result word, actual tdata %h found %b last %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    error_count++;
                end else begin
                    want = pending_rankings.pop_front();
                    words_checked++;
                    check_field("rank",  Q_BITS'(want.rank),     Q_BITS'(m_tdata[1:0]));
                    check_field("id",    want.id,                m_tdata[17:2]);
                    check_field("mask",  Q_BITS'(want.mask),     Q_BITS'(m_tdata[22:18]));
                    check_field("score", want.score,             m_tdata[38:23]);
                    check_field("found", Q_BITS'(want.found),    Q_BITS'(m_tuser));
                    check_field("last",  Q_BITS'(want.last_res), Q_BITS'(m_tlast));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic send_item(input logic [ID_W-1:0] id, input logic [MASK_W-1:0] mask,
                             input logic skip, input logic eoc);
        t_catalog_item it;
        it = '{id: id, mask: mask, skip: skip, eoc: eoc};
        items_to_send = {items_to_send, it};
    endtask

    // hold off until every word is accepted and every result taken, then
    // give the insertion / clear cycles time to settle
    task automatic drain;
        while (items_to_send.size() != 0 || s_tvalid || pending_rankings.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_weight(input logic [CFG_IDX_W-1:0] idx, input logic [W_BITS-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        profile_w[idx] = val;
        profile_writes++;
    endtask

    task automatic set_profile(input logic [W_BITS-1:0] action, input logic [W_BITS-1:0] comedy,
                               input logic [W_BITS-1:0] drama, input logic [W_BITS-1:0] scifi,
                               input logic [W_BITS-1:0] animation);
        write_weight(CFG_W_ACTION,    action);
        write_weight(CFG_W_COMEDY,    comedy);
        write_weight(CFG_W_DRAMA,     drama);
        write_weight(CFG_W_SCIFI,     scifi);
        write_weight(CFG_W_ANIMATION, animation);
    endtask

    // ---------------------------------------------------------------
    // run watchdog
    // ---------------------------------------------------------------
    initial begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin : main_seq
        logic [MASK_W-1:0] mask;
        int pick;
        int idle_sel [4];
        int stall_sel [4];
        idle_sel  = '{0, 87, 0, 27};
        stall_sel = '{0, 0, 87, 27};
        for (int g = 0; g < NUM_GENRES; g++) profile_w[g] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part, no idling ---
        // all-zero profile after reset: every dot is zero, so an empty ranking
        send_item(16'h1234, 5'b11111, 1'b0, 1'b1);
        drain();

        set_profile(2'd3, 2'd0, 2'd2, 2'd1, 2'd3);
        send_item(16'h0000, 5'b00000, 1'b0, 1'b0);   // empty mask
        send_item(16'hFFFF, 5'b11111, 1'b1, 1'b0);   // skipped, would be best
        send_item(16'h0001, 5'b00001, 1'b0, 1'b0);
        send_item(16'h0002, 5'b00001, 1'b0, 1'b0);   // tie, stays behind 1
        send_item(16'h0003, 5'b11111, 1'b0, 1'b0);
        send_item(16'h0004, 5'b10000, 1'b0, 1'b0);   // tie with a full list: dropped
        send_item(16'h0005, 5'b00100, 1'b0, 1'b0);   // worse than all kept
        send_item(16'h0006, 5'b01001, 1'b0, 1'b0);
        send_item(16'h0007, 5'b10101, 1'b0, 1'b1);   // new best, pushes out the worst
        send_item(16'h8000, 5'b00010, 1'b0, 1'b1);   // zero-weight genre only
        send_item(16'h0009, 5'b11111, 1'b1, 1'b1);   // catalog of one skipped item
        send_item(16'h000A, 5'b00101, 1'b0, 1'b0);
        send_item(16'h000B, 5'b11000, 1'b0, 1'b0);
        drain();
        // profile cleared mid-catalog: kept dots stay, scores saturate
        set_profile(2'd0, 2'd0, 2'd0, 2'd0, 2'd0);
        send_item(16'h000C, 5'b11111, 1'b0, 1'b1);
        drain();
        set_profile(2'd3, 2'd3, 2'd3, 2'd3, 2'd3);
        send_item(16'hFFFF, 5'b11111, 1'b0, 1'b0);   // largest dot
        send_item(16'h000E, 5'b00001, 1'b0, 1'b0);
        send_item(16'h000F, 5'b00011, 1'b0, 1'b0);
        send_item(16'h0010, 5'b00111, 1'b0, 1'b1);
        drain();

        // --- random part: four idle/stall mixes, profile written each time (all threes first, then random) ---
        // a phase can end inside a catalog, so profiles change mid-run too
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 0) begin
                set_profile(2'd3, 2'd3, 2'd3, 2'd3, 2'd3);
            end else begin
                set_profile(W_BITS'($urandom_range(3)), W_BITS'($urandom_range(3)),
                            W_BITS'($urandom_range(3)), W_BITS'($urandom_range(3)),
                            W_BITS'($urandom_range(3)));
            end
            send_idle_pct  = idle_sel[ph];
            recv_stall_pct = stall_sel[ph];
            for (int n = 0; n < 55; n++) begin
                pick = $urandom_range(9);
                if (pick == 0) mask = 5'b00000;
                else if (pick == 1) mask = 5'b11111;
                else mask = MASK_W'($urandom_range(31));
                send_item(ID_W'($urandom), mask, $urandom_range(5) == 0,
                          ($urandom_range(7) == 0) || (ph == 3 && n == 54));
            end
            drain();   // sender holds off until every ranking has come back
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (20) @(posedge clk);

        if (pending_rankings.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, pending_rankings.size());
            error_count++;
        end
        $display("run: %0d catalog words over %0d catalogs, %0d ranked words compared,",
                 items_accepted, catalogs_closed, words_checked);
        $display("     %0d profile writes, four backpressure mixes, %0d errors",
                 profile_writes, error_count);
        if (error_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: cosine_similarity_top_k.f
rtl/csk_pkg.sv
rtl/csk_ctrl.sv
rtl/csk_dp.sv
rtl/cosine_similarity_top_k.sv
rtl/csk_checker.sv
bench/tb.sv
